[hw/rtl/tope_pkg.sv]
package tope_pkg;

  localparam int MAX_ENTRIES = 128;
  localparam int NAME_BYTES  = 256;
  localparam int HASH_BYTES  = 32;
  localparam int MODE_BUFFER = 16;

  // Last legal count in each field, and the entry limit as an index value
  localparam logic [7:0] MODE_LAST = 8'(MODE_BUFFER - 1);
  localparam logic [7:0] NAME_LAST = 8'(NAME_BYTES - 1);
  localparam logic [7:0] HASH_LAST = 8'(HASH_BYTES - 1);
  localparam logic [7:0] MAX_IDX   = 8'(MAX_ENTRIES);

  localparam logic [7:0] ASCII_SPACE = 8'h20;
  localparam logic [7:0] ASCII_NUL   = 8'h00;
  localparam logic [7:0] ASCII_PLUS  = 8'h2B;
  localparam logic [7:0] ASCII_MINUS = 8'h2D;
  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_SEVEN = 8'h37;
  localparam logic [7:0] ASCII_TAB   = 8'h09;
  localparam logic [7:0] ASCII_CR    = 8'h0D;

  localparam logic [2:0] CLS_MODE     = 3'd0;
  localparam logic [2:0] CLS_SPACE    = 3'd1;
  localparam logic [2:0] CLS_NAME     = 3'd2;
  localparam logic [2:0] CLS_NAME_END = 3'd3;
  localparam logic [2:0] CLS_HASH     = 3'd4;
  localparam logic [2:0] CLS_LIMIT    = 3'd5;
  localparam logic [2:0] CLS_ERROR    = 3'd6;

  localparam logic [1:0] ST_RUN = 2'd0;
  localparam logic [1:0] ST_OK  = 2'd1;
  localparam logic [1:0] ST_BAD = 2'd2;

  typedef enum logic [4:0] {
    PH_MODE  = 5'b00001,
    PH_NAME  = 5'b00010,
    PH_HASH  = 5'b00100,
    PH_LIMIT = 5'b01000,
    PH_ERROR = 5'b10000
  } phase_t;

  typedef enum logic [3:0] {
    SUB_BLANK  = 4'b0001,
    SUB_SIGN   = 4'b0010,
    SUB_DIGITS = 4'b0100,
    SUB_STOP   = 4'b1000
  } sub_t;

  typedef struct packed {
    phase_t      phase;
    sub_t        sub;
    logic        neg;
    logic [31:0] acc;
    logic [7:0]  cnt;
    logic [7:0]  ent_done;
  } tope_state_t;

  typedef struct packed {
    logic [2:0]  cls;
    logic [7:0]  pos;
    logic [31:0] mode;
    logic [7:0]  idx;
    logic        complete;
    logic [1:0]  status;
  } tope_result_t;

  localparam tope_state_t STATE_RESET = '{
    phase:    PH_MODE,
    sub:      SUB_BLANK,
    neg:      1'b0,
    acc:      32'd0,
    cnt:      8'd0,
    ent_done: 8'd0
  };

endpackage

[hw/rtl/tope_step.sv]
module tope_step (
  input  tope_pkg::tope_state_t  st_i,
  input  logic [7:0]             byte_i,
  input  logic                   last_i,
  output tope_pkg::tope_state_t  st_o,
  output tope_pkg::tope_result_t res_o
);
  import tope_pkg::*;

  logic        is_digit;
  logic        is_blank;
  logic        is_sign;
  sub_t        dec_sub;
  logic        dec_neg;
  logic [31:0] dec_acc;
  logic [31:0] mode_new;
  logic [31:0] mode_cur;
  logic        err;
  logic        boundary;
  logic [7:0]  ent_inc;

  assign is_digit = (byte_i >= ASCII_ZERO) && (byte_i <= ASCII_SEVEN);
  assign is_blank = (byte_i >= ASCII_TAB) && (byte_i <= ASCII_CR);
  assign is_sign  = (byte_i == ASCII_PLUS) || (byte_i == ASCII_MINUS);
  assign ent_inc  = st_i.ent_done + 8'd1;

  // Octal decode of one mode byte, strtol style
  always_comb begin
    dec_sub = st_i.sub;
    dec_neg = st_i.neg;
    dec_acc = st_i.acc;
    if (st_i.sub == SUB_BLANK && is_blank) begin
      dec_sub = st_i.sub;
    end else if (st_i.sub == SUB_BLANK && is_sign) begin
      dec_neg = (byte_i == ASCII_MINUS);
      dec_sub = SUB_SIGN;
    end else if (st_i.sub == SUB_STOP) begin
      dec_sub = SUB_STOP;
    end else if (is_digit) begin
      dec_acc = {st_i.acc[28:0], byte_i[2:0]};
      dec_sub = SUB_DIGITS;
    end else begin
      dec_sub = SUB_STOP;
    end
  end

  assign mode_new = dec_neg ? (32'd0 - dec_acc) : dec_acc;
  assign mode_cur = st_i.neg ? (32'd0 - st_i.acc) : st_i.acc;

  always_comb begin
    st_o     = st_i;
    res_o    = '{cls: CLS_ERROR, pos: 8'd0, mode: 32'd0, idx: st_i.ent_done,
                 complete: 1'b0, status: ST_BAD};
    err      = 1'b0;
    boundary = 1'b0;
    unique case (st_i.phase)
      PH_MODE: begin
        if (byte_i == ASCII_SPACE) begin
          res_o.cls  = CLS_SPACE;
          res_o.pos  = st_i.cnt;
          res_o.mode = mode_cur;
          st_o.phase = PH_NAME;
          st_o.cnt   = 8'd0;
        end else if (st_i.cnt >= MODE_LAST) begin
          err = 1'b1;
        end else begin
          res_o.cls  = CLS_MODE;
          res_o.pos  = st_i.cnt;
          res_o.mode = mode_new;
          st_o.sub   = dec_sub;
          st_o.neg   = dec_neg;
          st_o.acc   = dec_acc;
          st_o.cnt   = st_i.cnt + 8'd1;
        end
      end
      PH_NAME: begin
        if (byte_i == ASCII_NUL) begin
          res_o.cls  = CLS_NAME_END;
          res_o.pos  = st_i.cnt;
          res_o.mode = mode_cur;
          st_o.phase = PH_HASH;
          st_o.cnt   = 8'd0;
        end else if (st_i.cnt >= NAME_LAST) begin
          err = 1'b1;
        end else begin
          res_o.cls  = CLS_NAME;
          res_o.pos  = st_i.cnt;
          res_o.mode = mode_cur;
          st_o.cnt   = st_i.cnt + 8'd1;
        end
      end
      PH_HASH: begin
        res_o.cls  = CLS_HASH;
        res_o.pos  = st_i.cnt;
        res_o.mode = mode_cur;
        st_o.cnt   = st_i.cnt + 8'd1;
        if (st_i.cnt >= HASH_LAST) begin
          res_o.complete = 1'b1;
          boundary       = 1'b1;
          st_o           = STATE_RESET;
          st_o.ent_done  = ent_inc;
          if (ent_inc >= MAX_IDX) begin
            st_o.phase = PH_LIMIT;
          end
        end
      end
      PH_LIMIT: begin
        res_o.cls = CLS_LIMIT;
        res_o.idx = MAX_IDX;
        boundary  = 1'b1;
      end
      default: begin
        err = 1'b1;
      end
    endcase

    // End of object anywhere but an entry boundary or past the entry limit is malformed
    if (last_i && !boundary) begin
      err = 1'b1;
    end

    if (err) begin
      st_o.phase     = PH_ERROR;
      st_o.ent_done  = st_i.ent_done;
      res_o.cls      = CLS_ERROR;
      res_o.pos      = 8'd0;
      res_o.mode     = 32'd0;
      res_o.idx      = st_i.ent_done;
      res_o.complete = 1'b0;
      res_o.status   = ST_BAD;
    end else if (last_i) begin
      res_o.status = ST_OK;
      st_o         = STATE_RESET;
    end else begin
      res_o.status = ST_RUN;
    end
  end

endmodule

[hw/rtl/tree_object_entry_parser_top.sv]
// A request accepted into the input stage is parsed into the result register, which drives the outputs.
// Throughput: one byte per cycle, sustained while the result side does not stall.
// The parse state and the byte decode are combinational between the input and result registers.
// Reset (rst_n low, synchronous): both stages empty, parser back at the mode field of
// entry zero with the error flag clear; an error otherwise holds until reset.
module tree_object_entry_parser_top (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_object,

  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_byte_class,
  output logic [7:0]  out_field_position,
  output logic [31:0] out_mode_value,
  output logic [7:0]  out_entry_index,
  output logic        out_entry_complete,
  output logic [1:0]  out_parse_status
);
  import tope_pkg::*;

  // Input stage: holds one request until the parser can take it
  logic         a_valid_r;
  logic         a_valid_nxt;
  logic [7:0]   a_byte_r;
  logic         a_last_r;

  // Parser state and the result register
  tope_state_t  state_r;
  tope_state_t  state_nxt;
  tope_result_t res_r;
  tope_result_t res_nxt;
  logic         out_valid_r;
  logic         out_valid_nxt;

  logic         res_free;
  logic         a_fire;
  logic         a_load;

  // The result register can take a new value when empty or being drained
  assign res_free = !out_valid_r || !out_stall;
  // Advance the buffered request into the parser
  assign a_fire   = a_valid_r && res_free;
  // Refill the input stage when it is empty or empties this cycle
  assign a_load   = !a_valid_r || res_free;
  assign in_stall = !a_load;

  tope_step u_step (
    .st_i   (state_r),
    .byte_i (a_byte_r),
    .last_i (a_last_r),
    .st_o   (state_nxt),
    .res_o  (res_nxt)
  );

  always_comb begin
    a_valid_nxt = a_valid_r;
    if (a_load) begin
      a_valid_nxt = in_valid;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_free) begin
      out_valid_nxt = a_valid_r;
    end
  end

  // Control state: cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= STATE_RESET;
    end else begin
      a_valid_r   <= a_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (a_fire) begin
        state_r <= state_nxt;
      end
    end
  end

  // Payload: capture on load, hold otherwise
  always_ff @(posedge clk) begin
    if (a_load && in_valid) begin
      a_byte_r <= in_data_byte;
      a_last_r <= in_end_of_object;
    end
    if (a_fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_byte_class     = res_r.cls;
  assign out_field_position = res_r.pos;
  assign out_mode_value     = res_r.mode;
  assign out_entry_index    = res_r.idx;
  assign out_entry_complete = res_r.complete;
  assign out_parse_status   = res_r.status;

  // Stall only while a request is parked in the input stage
  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> a_valid_r)
    else $error("input stalled with empty input stage");

  // Once in error, every later byte reports the error class
  a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (a_fire && state_r.phase == PH_ERROR) |=>
      (out_byte_class == CLS_ERROR && out_parse_status == ST_BAD))
    else $error("byte after error not reported as error");

  // Entry completion only on a hash byte
  a_complete_on_hash: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_entry_complete) |-> (out_byte_class == CLS_HASH))
    else $error("entry complete outside hash field");

  // Entry count never runs past the limit
  a_entries_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.ent_done <= MAX_IDX)
    else $error("entry count past limit");

endmodule

[test/tb_tree_object_entry_parser_top.sv]
module tb_tree_object_entry_parser_top;
  import tope_pkg::*;

  // Pacing of the stream: each request carries the pacing of the stretch it was built in
  typedef enum logic [1:0] {
    PACE_FREE,
    PACE_SEND_GAPS,
    PACE_RECV_STALLS,
    PACE_BOTH
  } pace_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    pace_t      pace;
  } byte_req_t;

  localparam int PACE_LEN  = 173;   // requests per pacing stretch
  localparam int HOLD_LEN  = 150;   // cycles of a long receiver hold-off
  localparam int MAX_SHOWN = 20;    // field mismatch lines printed at most

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_end_of_object = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_byte_class;
  logic [7:0]  out_field_position;
  logic [31:0] out_mode_value;
  logic [7:0]  out_entry_index;
  logic        out_entry_complete;
  logic [1:0]  out_parse_status;

  tree_object_entry_parser_top u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_data_byte       (in_data_byte),
    .in_end_of_object   (in_end_of_object),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_byte_class     (out_byte_class),
    .out_field_position (out_field_position),
    .out_mode_value     (out_mode_value),
    .out_entry_index    (out_entry_index),
    .out_entry_complete (out_entry_complete),
    .out_parse_status   (out_parse_status)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Percent of cycles the sender idles / the receiver stalls, per pacing stretch
  int unsigned send_gap_pct[4] = '{0, 75, 0, 18};
  int unsigned recv_stall_pct[4] = '{0, 0, 75, 18};

  byte_req_t    byte_q[$];      // requests not yet offered
  tope_result_t expected_q[$];  // predicted results, oldest first
  int unsigned  n_built;
  int unsigned  n_sent;
  int unsigned  mismatches;
  int unsigned  entries_seen;
  int unsigned  objects_ok;
  int unsigned  class_seen[8];
  int unsigned  hold_left;
  int unsigned  holds_done;
  pace_t        cur_pace = PACE_FREE;

  // ---------------------------------------------------------------------------
  // Parser state as the predictor tracks it
  // ---------------------------------------------------------------------------
  phase_t      pr_phase;
  sub_t        pr_sub;
  logic        pr_neg;
  logic [31:0] pr_acc;
  logic [8:0]  pr_cnt;
  logic [7:0]  pr_done;

  function automatic void restart_entry();
    pr_phase = PH_MODE;
    pr_sub   = SUB_BLANK;
    pr_neg   = 1'b0;
    pr_acc   = '0;
    pr_cnt   = '0;
  endfunction

  // Mode with the sign applied, wrapping at 32 bits
  function automatic logic [31:0] mode_now();
    return pr_neg ? 32'd0 - pr_acc : pr_acc;
  endfunction

  // Advance the parser by one byte and return the result it produces
  function automatic tope_result_t parse_byte(input logic [7:0] b, input logic last);
    tope_result_t r;
    logic         err;
    logic         boundary;
    logic         is_blank;
    logic         is_digit;
    r        = '{cls: CLS_ERROR, pos: 8'd0, mode: 32'd0, idx: pr_done, complete: 1'b0,
                 status: ST_BAD};
    err      = 1'b0;
    boundary = 1'b0;
    is_blank = (b >= ASCII_TAB && b <= ASCII_CR);
    is_digit = (b >= ASCII_ZERO && b <= ASCII_SEVEN);
    case (pr_phase)
      PH_MODE: begin
        if (b == ASCII_SPACE) begin
          r.cls    = CLS_SPACE;
          r.pos    = pr_cnt[7:0];
          r.mode   = mode_now();
          pr_phase = PH_NAME;
          pr_cnt   = '0;
        end else if (pr_cnt + 1 >= MODE_BUFFER) begin
          err = 1'b1;
        end else begin
          r.cls = CLS_MODE;
          r.pos = pr_cnt[7:0];
          // strtol style: skip leading blanks, take one sign, then digits until a stop
          if (pr_sub == SUB_BLANK && (b == ASCII_PLUS || b == ASCII_MINUS)) begin
            pr_neg = (b == ASCII_MINUS);
            pr_sub = SUB_SIGN;
          end else if (!(pr_sub == SUB_BLANK && is_blank) && pr_sub != SUB_STOP) begin
            if (is_digit) begin
              pr_acc = {pr_acc[28:0], 3'b000} + {29'd0, b[2:0]};
              pr_sub = SUB_DIGITS;
            end else begin
              pr_sub = SUB_STOP;
            end
          end
          r.mode = mode_now();
          pr_cnt = pr_cnt + 9'd1;
        end
      end
      PH_NAME: begin
        if (b == ASCII_NUL) begin
          r.cls    = CLS_NAME_END;
          r.pos    = pr_cnt[7:0];
          r.mode   = mode_now();
          pr_phase = PH_HASH;
          pr_cnt   = '0;
        end else if (pr_cnt + 1 >= NAME_BYTES) begin
          err = 1'b1;
        end else begin
          r.cls  = CLS_NAME;
          r.pos  = pr_cnt[7:0];
          r.mode = mode_now();
          pr_cnt = pr_cnt + 9'd1;
        end
      end
      PH_HASH: begin
        r.cls  = CLS_HASH;
        r.pos  = pr_cnt[7:0];
        r.mode = mode_now();
        pr_cnt = pr_cnt + 9'd1;
        if (pr_cnt >= HASH_BYTES) begin
          r.complete = 1'b1;
          pr_done    = pr_done + 8'd1;
          restart_entry();
          boundary = 1'b1;
          if (pr_done >= MAX_ENTRIES) pr_phase = PH_LIMIT;
        end
      end
      PH_LIMIT: begin
        r.cls    = CLS_LIMIT;
        r.idx    = MAX_IDX;
        boundary = 1'b1;
      end
      default: begin
        err = 1'b1;
      end
    endcase

    // The object may only end on an entry boundary or past the entry limit
    if (!err && last && !boundary) err = 1'b1;

    if (err) begin
      pr_phase = PH_ERROR;
      r = '{cls: CLS_ERROR, pos: 8'd0, mode: 32'd0, idx: pr_done, complete: 1'b0,
            status: ST_BAD};
    end else if (last) begin
      r.status = ST_OK;
      restart_entry();
      pr_done = '0;
    end else begin
      r.status = ST_RUN;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus builders: append requests to the pending queue
  // ---------------------------------------------------------------------------
  task automatic put_byte(input logic [7:0] d, input logic last = 1'b0);
    byte_q.push_back('{data: d, last: last, pace: pace_t'((n_built / PACE_LEN) % 4)});
    n_built++;
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endtask

  function automatic logic [7:0] any_but(input logic [7:0] avoid);
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (b == avoid);
    return b;
  endfunction

  // Random mode field: optional blanks, optional sign, digits, then trailing junk
  task automatic put_mode();
    int unsigned total;
    int unsigned nb;
    int unsigned nd;
    bit          sgn;
    total = ($urandom_range(7) == 0) ? MODE_BUFFER - 1 : $urandom_range(0, 8);
    nb    = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0;
    sgn   = ($urandom_range(2) == 0);
    nd    = $urandom_range(0, MODE_BUFFER - 1);
    for (int unsigned i = 0; i < total; i++) begin
      if (i < nb) put_byte(ASCII_TAB + 8'($urandom_range(4)));
      else if (sgn && i == nb) put_byte($urandom_range(1) ? ASCII_MINUS : ASCII_PLUS);
      else if (i < nb + sgn + nd) put_byte(ASCII_ZERO + 8'($urandom_range(7)));
      else put_byte(any_but(ASCII_SPACE));
    end
  endtask

  // One entry: mode, space, name, zero byte and hash
  task automatic put_entry(input bit last);
    int unsigned pick;
    int unsigned label_len;
    pick      = $urandom_range(39);
    label_len = (pick == 0) ? NAME_BYTES - 1 : (pick < 4) ? 0 : $urandom_range(1, 10);
    put_mode();
    put_byte(ASCII_SPACE);
    for (int unsigned i = 0; i < label_len; i++) put_byte(any_but(ASCII_NUL));
    put_byte(ASCII_NUL);
    for (int i = 0; i < HASH_BYTES; i++)
      put_byte(8'($urandom_range(255)), last && i == HASH_BYTES - 1);
  endtask

  task automatic put_object(input int unsigned n_entries);
    for (int unsigned e = 0; e < n_entries; e++) put_entry(e == n_entries - 1);
  endtask

  // The error is sticky, so exactly one kind of malformed object closes the run
  task automatic put_broken_object();
    logic [7:0]  part[$];
    int unsigned cut;
    case ($urandom_range(2))
      0: begin
        // mode buffer overflow
        for (int i = 0; i < MODE_BUFFER; i++) put_byte(any_but(ASCII_SPACE));
      end
      1: begin
        // name overflow
        put_text("644 ");
        for (int i = 0; i < NAME_BYTES; i++) put_byte(any_but(ASCII_NUL));
      end
      default: begin
        // object ends in the middle of an entry
        part = '{ASCII_SEVEN, ASCII_ZERO, ASCII_SPACE, 8'h61, ASCII_NUL};
        for (int i = 0; i < HASH_BYTES; i++) part.push_back(8'($urandom_range(255)));
        cut = $urandom_range(0, part.size() - 2);
        for (int unsigned i = 0; i <= cut; i++) put_byte(part[i], i == cut);
      end
    endcase
    for (int i = 0; i < 24; i++) put_byte(8'($urandom_range(255)), $urandom_range(3) == 0);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offer pending requests, predict each one at acceptance
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    byte_req_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
      restart_entry();
      pr_done = '0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_q.push_back(parse_byte(in_data_byte, in_end_of_object));
        n_sent <= n_sent + 1;
      end
      // A stalled request holds; otherwise advance or idle.
      // During a receiver hold-off keep offering so the block fills up.
      if (!in_valid || !in_stall) begin
        if (byte_q.size() != 0 &&
            (hold_left != 0 || $urandom_range(99) >= send_gap_pct[byte_q[0].pace])) begin
          nxt = byte_q.pop_front();
          in_valid         <= 1'b1;
          in_data_byte     <= nxt.data;
          in_end_of_object <= nxt.last;
          cur_pace         <= nxt.pace;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-offs, twice in the run, counted here
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left  <= 0;
      holds_done <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if ((holds_done == 0 && n_sent >= 400) || (holds_done == 1 && n_sent >= 1200)) begin
      hold_left  <= HOLD_LEN;
      holds_done <= holds_done + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare each accepted result with the oldest prediction
  // ---------------------------------------------------------------------------
  function automatic void check_field(input string what, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= MAX_SHOWN)
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
    end
  endfunction

  always @(posedge clk) begin
    tope_result_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          $display("%0t: result with nothing expected, expected none, got class %0d",
                   $time, out_byte_class);
        end else begin
          want = expected_q.pop_front();
          check_field("byte_class", 32'(want.cls), 32'(out_byte_class));
          check_field("field_position", 32'(want.pos), 32'(out_field_position));
          check_field("mode_value", want.mode, out_mode_value);
          check_field("entry_index", 32'(want.idx), 32'(out_entry_index));
          check_field("entry_complete", 32'(want.complete), 32'(out_entry_complete));
          check_field("parse_status", 32'(want.status), 32'(out_parse_status));
          class_seen[want.cls]++;
          if (want.complete) entries_seen++;
          if (want.status == ST_OK) objects_ok++;
        end
      end
      out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct[cur_pace]);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned stop_at;

    // Directed: blank, plus sign and digits; hash bytes at the byte extremes
    put_byte(8'h0B);
    put_text("+0755 a");
    put_byte(ASCII_NUL);
    put_byte(8'h00);
    put_byte(8'hFF);
    put_byte(ASCII_SPACE);
    for (int i = 3; i < HASH_BYTES; i++) put_byte(8'($urandom_range(255)));
    // minus sign, digits stopped by a non-octal byte, empty name, end of object
    put_text("-17x3 ");
    put_byte(ASCII_NUL);
    for (int i = 0; i < HASH_BYTES; i++) put_byte(8'hA5 ^ 8'(i), i == HASH_BYTES - 1);
    // longest legal mode, wrapping past 32 bits; the next byte starts a new object
    put_text("777777777777777 ");
    put_byte(8'hFF);
    put_byte(ASCII_NUL);
    for (int i = 0; i < HASH_BYTES; i++) put_byte(8'h5A, i == HASH_BYTES - 1);

    // Random objects, then one malformed object to close the run
    stop_at = n_built + 1400;
    while (n_built < stop_at) put_object($urandom_range(1, 4));
    put_broken_object();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (byte_q.size() != 0 || in_valid || expected_q.size() != 0) @(negedge clk);
    repeat (20) @(posedge clk);

    $display("tb: %0d bytes checked, %0d entries completed, %0d objects closed cleanly",
             n_sent, entries_seen, objects_ok);
    $display("tb: classes mode/space/name/end/hash/limit/error = %0d/%0d/%0d/%0d/%0d/%0d/%0d",
             class_seen[CLS_MODE], class_seen[CLS_SPACE], class_seen[CLS_NAME],
             class_seen[CLS_NAME_END], class_seen[CLS_HASH], class_seen[CLS_LIMIT],
             class_seen[CLS_ERROR]);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4000000;
    $display("tb: failure");
    $finish;
  end

endmodule
